@@ rtl/asc_pkg.sv @@
// shared types and constants of the alphabet shift cipher
package asc_pkg;

	// item commands
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ENCRYPT = 2'd1,
		CMD_DECRYPT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// input item
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] char_in;
		logic [6:0] entry_index;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] char_out;
		logic       found;
	} out_item_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SEARCH,
		ST_FETCH,
		ST_EMIT
	} state_t;

	// configuration registers, selected by byte address bit 2
	localparam int          ADDR_W   = 3;
	localparam logic        REG_SIZE = 1'b0;
	localparam logic        REG_KEY  = 1'b1;
	localparam logic [7:0]  SIZE_RST = 8'd26;
	localparam logic [7:0]  KEY_RST  = 8'd1;

endpackage

@@ rtl/asc_ram.sv @@
// generic single write, single read ram with registered read data
module asc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/asc_front.sv @@
// front end: takes items, drops those with no effect, queues the rest
module asc_front #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  asc_pkg::in_item_t item,
	output logic             q_valid,
	output asc_pkg::in_item_t q_item,
	input  logic             q_pop
);

	asc_pkg::in_item_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              keep;
	logic              wr_en;
	logic              rd_en;

	// classify: unused command and loads past the table are dropped
	always_comb begin
		case (item.cmd)
			asc_pkg::CMD_LOAD:    keep = (9'(item.entry_index) < 9'(TABLE_DEPTH));
			asc_pkg::CMD_ENCRYPT: keep = 1'b1;
			asc_pkg::CMD_DECRYPT: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign wr_en   = push && !full && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign rd_en   = q_pop && q_valid;
	assign q_item  = slot_q[rd_ptr_q];

	// two entry queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/asc_back.sv @@
// back end: table writes, key reduction, first-match search, result register
module asc_back #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  asc_pkg::in_item_t  q_item,
	output logic               q_pop,
	input  logic [7:0]         alphabet_size,
	input  logic [7:0]         shift_key,
	output logic               empty,
	input  logic               pop,
	output asc_pkg::out_item_t result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);

	asc_pkg::state_t    state_q;
	asc_pkg::state_t    state_d;
	asc_pkg::cmd_t      cmd_q;
	logic [7:0]         ch_q;
	logic [NW-1:0]      rem_q;
	logic [2:0]         bit_q;
	logic [NW-1:0]      scan_q;
	logic               pend_q;
	logic [AW-1:0]      pend_pos_q;
	logic [AW-1:0]      dst_q;
	logic               hit_q;
	logic               out_valid_q;
	asc_pkg::out_item_t out_item_q;

	logic [8:0]         n_sat;
	logic [NW-1:0]      n;
	logic [NW:0]        div_shift;
	logic [NW-1:0]      rem_next;
	logic [NW:0]        pos_e;
	logic [NW:0]        key_e;
	logic [NW:0]        n_e;
	logic [NW:0]        dst_sum;
	logic [AW-1:0]      dst;
	logic               issue;
	logic               hit;
	logic               miss;
	logic               out_free;
	logic               we;
	logic [AW-1:0]      raddr;
	logic [7:0]         rdata;

	// active alphabet size, saturated to the table depth
	assign n_sat = ({1'b0, alphabet_size} > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH)
		: {1'b0, alphabet_size};
	assign n = n_sat[NW-1:0];

	// one restoring division step of key mod size
	always_comb begin
		div_shift = {rem_q, shift_key[bit_q]};
		if (div_shift >= {1'b0, n}) begin
			rem_next = NW'(div_shift - {1'b0, n});
		end else begin
			rem_next = div_shift[NW-1:0];
		end
	end

	// target position of a hit, wrapped once
	always_comb begin
		pos_e = (NW + 1)'(pend_pos_q);
		key_e = {1'b0, rem_q};
		n_e   = {1'b0, n};
		if (cmd_q == asc_pkg::CMD_ENCRYPT) begin
			dst_sum = pos_e + key_e;
			if (dst_sum >= n_e) begin
				dst_sum = dst_sum - n_e;
			end
		end else if (pos_e >= key_e) begin
			dst_sum = pos_e - key_e;
		end else begin
			dst_sum = pos_e + n_e - key_e;
		end
		dst = dst_sum[AW-1:0];
	end

	// search status: data of the previous read is compared this cycle
	assign issue    = (scan_q < n);
	assign hit      = pend_q && (rdata == ch_q);
	assign miss     = !pend_q && !issue;
	assign out_free = !out_valid_q || pop;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			asc_pkg::ST_IDLE: begin
				if (q_valid && q_item.cmd != asc_pkg::CMD_LOAD) begin
					state_d = asc_pkg::ST_MOD;
				end
			end
			asc_pkg::ST_MOD: begin
				if (bit_q == 3'd0) begin
					state_d = asc_pkg::ST_SEARCH;
				end
			end
			asc_pkg::ST_SEARCH: begin
				if (hit) begin
					state_d = asc_pkg::ST_FETCH;
				end else if (miss) begin
					state_d = asc_pkg::ST_EMIT;
				end
			end
			asc_pkg::ST_FETCH: state_d = asc_pkg::ST_EMIT;
			asc_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = asc_pkg::ST_IDLE;
				end
			end
			default: state_d = asc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop = 1'b0;
		we    = 1'b0;
		raddr = dst_q;
		case (state_q)
			asc_pkg::ST_IDLE: begin
				q_pop = q_valid;
				we    = q_valid && (q_item.cmd == asc_pkg::CMD_LOAD);
			end
			asc_pkg::ST_SEARCH: raddr = scan_q[AW-1:0];
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		case (state_q)
			asc_pkg::ST_IDLE: begin
				cmd_q <= q_item.cmd;
				ch_q  <= q_item.char_in;
				rem_q <= '0;
				bit_q <= 3'd7;
			end
			asc_pkg::ST_MOD: begin
				rem_q  <= rem_next;
				bit_q  <= bit_q - 3'd1;
				scan_q <= '0;
				pend_q <= 1'b0;
			end
			asc_pkg::ST_SEARCH: begin
				pend_q     <= issue;
				pend_pos_q <= scan_q[AW-1:0];
				if (issue) begin
					scan_q <= scan_q + NW'(1);
				end
				dst_q <= dst;
				hit_q <= hit;
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == asc_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == asc_pkg::ST_EMIT && out_free) begin
			out_item_q.char_out <= hit_q ? rdata : ch_q;
			out_item_q.found    <= hit_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_item_q;

	// alphabet table
	asc_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(q_item.entry_index)),
		.wdata (q_item.char_in),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

@@ rtl/alphabet_shift_cipher_unit.sv @@
// top level of the alphabet shift cipher: register port, front and back ends
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  input    | push / full           | item (cmd, char_in, entry_index)
//  result   | empty / pop           | result (char_out, found)
//  config   | psel penable pwrite   | paddr, pwdata, prdata (size, key)
//
// An encrypt or decrypt item leaves the queue, has its key reduced mod the active
// size, walks the table for the first match, reads the target after a hit and
// posts the result. A load is written to the table as it leaves the queue. Reset
// clears the queue and the result register; the table is undefined until written.
// The two entry queue takes items while the back end works; the back end waits
// while an unpopped result holds its register.
module alphabet_shift_cipher_unit #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  asc_pkg::in_item_t            item,
	output logic                         empty,
	input  logic                         pop,
	output asc_pkg::out_item_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [asc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [7:0]        size_q;
	logic [7:0]        key_q;
	logic              cfg_wr;
	logic              q_valid;
	logic              q_pop;
	asc_pkg::in_item_t q_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= asc_pkg::SIZE_RST;
			key_q  <= asc_pkg::KEY_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == asc_pkg::REG_SIZE) begin
				size_q <= pwdata[7:0];
			end else begin
				key_q <= pwdata[7:0];
			end
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			asc_pkg::REG_KEY: prdata = {24'd0, key_q};
			default:          prdata = {24'd0, size_q};
		endcase
	end

	asc_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	asc_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.alphabet_size (size_q),
		.shift_key     (key_q),
		.empty         (empty),
		.pop           (pop),
		.result        (result)
	);

endmodule
